// ===== src/bcu_pkg.sv =====
`default_nettype none

package bcu_pkg;

   // Width of the coefficient datapath; the port stays 64 bits.
   localparam int RESULT_WIDTH   = 64;
   localparam int OUT_WIDTH      = 64;
   localparam int ARG_WIDTH      = 8;

   // Running value times (n - i) before the exact divide.
   localparam int PROD_WIDTH     = RESULT_WIDTH + ARG_WIDTH;

   // Divider retires this many quotient bits per cycle.
   localparam int DIV_RADIX_BITS = 8;
   localparam int DIV_CYCLES     = (PROD_WIDTH + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   localparam int DIV_WIDTH      = DIV_CYCLES * DIV_RADIX_BITS;
   localparam int CNT_WIDTH      = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic load;      // capture n, k; start a new transaction
      logic mul;       // running value times (n - i) into divider
      logic div;       // one radix step of the exact divide
      logic step;      // commit quotient, advance loop index
      logic set_ovf;   // quotient passed the result width
      logic out_load;  // move result into the output register
   } cmd_type;

   typedef struct packed {
      logic step_done; // loop index reached reduced k
      logic div_last;  // final divider cycle this step
      logic over;      // quotient exceeds result width
      logic out_busy;  // output register holds an untaken result
   } status_type;

endpackage

`default_nettype wire

// ===== src/bcu_req_if.sv =====
`default_nettype none

interface bcu_req_if;
   logic                        valid;
   logic                        ready;
   logic [bcu_pkg::ARG_WIDTH-1:0] set_size;
   logic [bcu_pkg::ARG_WIDTH-1:0] choose_count;

   modport source (output valid, output set_size, output choose_count, input ready);
   modport sink   (input valid, input set_size, input choose_count, output ready);
endinterface

`default_nettype wire

// ===== src/bcu_rsp_if.sv =====
`default_nettype none

interface bcu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcu_pkg::OUT_WIDTH-1:0] coefficient;
   logic                          overflow;

   modport source (output valid, output coefficient, output overflow, input ready);
   modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/bcu_datapath.sv =====
`default_nettype none

module bcu_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bcu_pkg::ARG_WIDTH-1:0] set_size,
   input  wire logic [bcu_pkg::ARG_WIDTH-1:0] choose_count,
   input  wire bcu_pkg::cmd_type              cmd,
   output bcu_pkg::status_type                status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bcu_pkg::OUT_WIDTH-1:0]      coefficient,
   output logic                               overflow
);

   localparam int RW = bcu_pkg::RESULT_WIDTH;
   localparam int AW = bcu_pkg::ARG_WIDTH;
   localparam int DW = bcu_pkg::DIV_WIDTH;
   localparam int RB = bcu_pkg::DIV_RADIX_BITS;

   logic [AW-1:0]                  n_ff, k_ff, i_ff;
   logic [RW-1:0]                  val_ff;
   logic                           ovf_ff;
   logic [DW-1:0]                  quot_ff, quot_in;
   logic [AW-1:0]                  rem_ff, rem_in;
   logic [bcu_pkg::CNT_WIDTH-1:0]  cnt_ff;
   logic                           rsp_valid_ff;
   logic [bcu_pkg::OUT_WIDTH-1:0]  coef_ff;
   logic                           out_ovf_ff;

   logic [AW-1:0]                  diff_nk, k_red, mult;
   logic                           invalid;
   logic [bcu_pkg::PROD_WIDTH-1:0] product;
   logic [AW:0]                    divisor;

   // k > n gives zero with no loop steps; otherwise k becomes min(k, n-k)
   assign invalid = choose_count > set_size;
   assign diff_nk = set_size - choose_count;
   assign k_red   = (choose_count > diff_nk) ? diff_nk : choose_count;

   assign mult    = n_ff - i_ff;
   assign product = bcu_pkg::PROD_WIDTH'(val_ff) * bcu_pkg::PROD_WIDTH'(mult);
   assign divisor = {1'b0, i_ff} + (AW+1)'(1);

   // Restoring division, RB quotient bits per cycle; remainder stays below divisor
   always_comb begin
      logic [DW-1:0] q;
      logic [AW-1:0] r;
      logic [AW:0]   t;
      q = quot_ff;
      r = rem_ff;
      for (int b = 0; b < RB; b++) begin
         t = {r, q[DW-1]};
         q = {q[DW-2:0], 1'b0};
         if (t >= divisor) begin
            t    = t - divisor;
            q[0] = 1'b1;
         end
         r = t[AW-1:0];
      end
      quot_in = q;
      rem_in  = r;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= set_size;
         k_ff   <= invalid ? '0 : k_red;
         i_ff   <= '0;
         val_ff <= invalid ? '0 : RW'(1);
         ovf_ff <= 1'b0;
      end
      if (cmd.mul) begin
         quot_ff <= DW'(product);
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.div) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (cmd.step) begin
         val_ff <= quot_ff[RW-1:0];
         i_ff   <= i_ff + 1'b1;
      end
      if (cmd.set_ovf) begin
         ovf_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         coef_ff    <= ovf_ff ? bcu_pkg::OUT_WIDTH'({RW{1'b1}})
                              : bcu_pkg::OUT_WIDTH'(val_ff);
         out_ovf_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.step_done = i_ff == k_ff;
   assign status.div_last  = cnt_ff == bcu_pkg::CNT_WIDTH'(bcu_pkg::DIV_CYCLES - 1);
   assign status.over      = |quot_ff[DW-1:RW];
   assign status.out_busy  = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign coefficient = coef_ff;
   assign overflow    = out_ovf_ff;

endmodule

`default_nettype wire

// ===== src/bcu_ctrl.sv =====
`default_nettype none

module bcu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire bcu_pkg::status_type status,
   output bcu_pkg::cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.step_done ? ST_FIN : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // first step past the result width ends the loop
            if (status.over) begin
               cmd.set_ovf = 1'b1;
               state_in    = ST_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FIN: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/binomial_coefficient_unit.sv =====
// Flow: accept, then a check; when the reduced k is 0 (or k > n) the result is loaded into
//   the output register once it is free. Otherwise s loop steps run (s = min(k, n-k), at
//   most 33 without overflow), and the loop ends at the step that overflows. A step is a
//   check, a 64x8 multiply, the radix-256 exact division and an update.
// One transaction at a time.
// Reset: synchronous, active high; clears the controller state and the result valid.
`default_nettype none

module binomial_coefficient_unit (
   input wire logic clock,
   input wire logic reset,
   bcu_req_if.sink  req_ch,
   bcu_rsp_if.source rsp_ch
);

   // Controller sequences the multiplicative loop; the datapath holds n, reduced k,
   // the loop index, the running value and the shift/subtract divider.
   bcu_pkg::cmd_type    cmd;
   bcu_pkg::status_type status;

   bcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Output register parts the two sides: a new transaction may be accepted while
   // the last result waits; the controller holds its result until the register frees.
   bcu_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .set_size     (req_ch.set_size),
      .choose_count (req_ch.choose_count),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .coefficient  (rsp_ch.coefficient),
      .overflow     (rsp_ch.overflow)
   );

   // Never overwrite a result that has not been taken.
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result register overwritten while pending");

   // Busy right after a transaction is accepted.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input accepted while busy");

   // Overflowed result is saturated.
   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.overflow) |->
         rsp_ch.coefficient == bcu_pkg::OUT_WIDTH'({bcu_pkg::RESULT_WIDTH{1'b1}}))
      else $error("overflow without saturation");

   // At most one datapath command per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.div, cmd.step, cmd.set_ovf, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire
